>>> rtl/core/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared command and status codes, the cell control word and default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int SPQ_DATA_W   = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the chain in the cycle a word is accepted.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-first queue built as a chain of sorted storage cells.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY entries in a row of cells, sorted by signed
// priority with the smallest number at cell 0. Each input word is either an
// insert or a delete and produces exactly one result word. An insert goes
// behind every stored entry of lower or equal priority, so equal priorities
// leave in arrival order; an insert into a full queue is dropped and reported
// with the full status. A delete returns the entry at the head, or reports
// the empty status with zero data. The queue takes one word per clock cycle
// while the held result is not stalled: the new priority is broadcast to
// all cells, each cell compares it against its own entry in the same cycle
// and then either holds, loads the new entry or takes its neighbor's. The
// result lands in an output register; a new word is accepted in the same
// cycle the previous result is taken, so back-to-back traffic flows at full
// rate. No clearing pass: reset clears only the fill count and out_valid.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_command,
  input  wire logic signed [SPQ_DATA_W-1:0] in_item_value,
  input  wire logic signed [SPQ_DATA_W-1:0] in_item_priority,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic signed [SPQ_DATA_W-1:0]      out_removed_value,
  output logic signed [SPQ_DATA_W-1:0]      out_removed_priority
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Fill count: entries below this index are valid.
  logic [CNT_W-1:0] count_r, count_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic signed [SPQ_DATA_W-1:0] out_value_r, out_value_nxt;
  logic signed [SPQ_DATA_W-1:0] out_prio_r, out_prio_nxt;

  logic       in_accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  logic [CAPACITY-1:0]          le_vec;
  logic signed [SPQ_DATA_W-1:0] cell_value [CAPACITY];
  logic signed [SPQ_DATA_W-1:0] cell_prio  [CAPACITY];

  // The output register frees up in the cycle its word is taken, so a new
  // word may enter whenever the held result is not stalled.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign ctrl.ins = in_accept && (command_t'(in_command) == CMD_INSERT) && !full;
  assign ctrl.del = in_accept && (command_t'(in_command) == CMD_DELETE) && !empty;

  // The chain of cells. Cell 0 is the head; each cell sees the compare
  // outcome of its left neighbor so that exactly one cell loads the new
  // entry and every cell behind it shifts one place to the right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         left_le;
    logic signed [SPQ_DATA_W-1:0] left_value, left_prio;
    logic signed [SPQ_DATA_W-1:0] right_value, right_prio;

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_value = in_item_value;
      assign left_prio  = in_item_priority;
    end else begin : g_body
      assign left_le    = le_vec[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count_r),
      .new_value   (in_item_value),
      .new_prio    (in_item_priority),
      .left_le     (left_le),
      .left_value  (left_value),
      .left_prio   (left_prio),
      .right_value (right_value),
      .right_prio  (right_prio),
      .le          (le_vec[i]),
      .value       (cell_value[i]),
      .prio        (cell_prio[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_prio_nxt   = out_prio_r;
    if (in_accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_DONE;
      out_value_nxt  = '0;
      out_prio_nxt   = '0;
      if (command_t'(in_command) == CMD_INSERT) begin
        if (full) begin
          out_status_nxt = STAT_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          out_status_nxt = STAT_EMPTY;
        end else begin
          count_nxt     = count_r - 1'b1;
          out_value_nxt = cell_value[0];
          out_prio_nxt  = cell_prio[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_removed_value    = out_value_r;
  assign out_removed_priority = out_prio_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Compare outcomes form a thermometer: a cell stays ahead only if all
  // cells before it do, so the chain stays sorted.
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    (le_vec & ~{le_vec[CAPACITY-2:0], 1'b1}) == '0)
    else $error("cell compare outcomes not a thermometer");

  // A successful insert grows the queue by one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the fill count");

  // A successful delete shrinks the queue by one entry.
  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the fill count");

  // An insert into a full queue reports the full status and leaves the count at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && full && (command_t'(in_command) == CMD_INSERT)) |=>
      (out_status_r == STAT_FULL) && (count_r == CNT_W'(CAPACITY)))
    else $error("dropped insert reported wrongly");

endmodule
`default_nettype wire

>>> rtl/core/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted chain and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                         clk,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic                         occupied,
  input  wire logic signed [SPQ_DATA_W-1:0] new_value,
  input  wire logic signed [SPQ_DATA_W-1:0] new_prio,
  input  wire logic                         left_le,
  input  wire logic signed [SPQ_DATA_W-1:0] left_value,
  input  wire logic signed [SPQ_DATA_W-1:0] left_prio,
  input  wire logic signed [SPQ_DATA_W-1:0] right_value,
  input  wire logic signed [SPQ_DATA_W-1:0] right_prio,
  output logic                              le,
  output logic signed [SPQ_DATA_W-1:0]      value,
  output logic signed [SPQ_DATA_W-1:0]      prio
);

  logic signed [SPQ_DATA_W-1:0] value_r, value_nxt;
  logic signed [SPQ_DATA_W-1:0] prio_r, prio_nxt;

  // An occupied entry whose priority does not exceed the new one stays ahead.
  assign le    = occupied && (prio_r <= new_prio);
  assign value = value_r;
  assign prio  = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctrl.ins) begin
      if (!left_le) begin
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end else if (!le) begin
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end
    end else if (ctrl.del) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule
`default_nettype wire

>>> dv/sorted_priority_queue_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and delete words with random gaps and checks every result
// word against a shadow sorted list kept inside the bench.
// ----------------------------------------------------------------------------
// A directed opening touches the priority and data extremes, equal
// priorities, a delete on an empty queue and an insert into a full one.
// Random bursts then lean toward filling, draining or mixing, so the queue
// keeps swinging between empty and full. The sender and the receiver idle
// at rates that change over three phases, and twice the receiver holds off
// for a long stretch so that the queue backs up and stalls its input.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef logic signed [SPQ_DATA_W-1:0] word_data_t;

  // One word offered on the input channel.
  typedef struct {
    command_t   cmd;
    word_data_t value;
    word_data_t prio;
  } queue_word_t;

  // One word the queue is expected to return.
  typedef struct {
    status_t    status;
    word_data_t value;
    word_data_t prio;
  } queue_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = 1'b0;
  word_data_t in_item_value = '0;
  word_data_t in_item_priority = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  word_data_t out_removed_value;
  word_data_t out_removed_priority;

  sorted_priority_queue #(
    .CAPACITY(SPQ_CAPACITY)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_item_value       (in_item_value),
    .in_item_priority    (in_item_priority),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_removed_value   (out_removed_value),
    .out_removed_priority(out_removed_priority)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words still to be offered, and the replies owed for accepted words.
  queue_word_t  pending_words[$];
  queue_reply_t owed_replies[$];

  // Shadow copy of the sorted list: index 0 is the head.
  word_data_t shadow_value[SPQ_CAPACITY];
  word_data_t shadow_prio[SPQ_CAPACITY];
  int         shadow_count = 0;

  int words_total = 0;
  int words_accepted = 0;
  int replies_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  int insert_count = 0;
  int delete_count = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int deepest_fill = 0;

  // Applies one accepted word to the shadow list and returns the reply the
  // queue owes for it. An insert walks past every entry of lower or equal
  // priority, which keeps equal priorities in arrival order.
  function automatic queue_reply_t serve_word(queue_word_t w);
    queue_reply_t reply;
    int pos;
    reply.status = STAT_DONE;
    reply.value  = '0;
    reply.prio   = '0;
    if (w.cmd == CMD_INSERT) begin
      insert_count++;
      if (shadow_count >= SPQ_CAPACITY) begin
        reply.status = STAT_FULL;
        full_hits++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= w.prio) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = w.value;
        shadow_prio[pos]  = w.prio;
        shadow_count++;
        if (shadow_count > deepest_fill) deepest_fill = shadow_count;
      end
    end else begin
      delete_count++;
      if (shadow_count == 0) begin
        reply.status = STAT_EMPTY;
        empty_hits++;
      end else begin
        reply.value = shadow_value[0];
        reply.prio  = shadow_prio[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_value[k-1] = shadow_value[k];
          shadow_prio[k-1]  = shadow_prio[k];
        end
        shadow_count--;
      end
    end
    return reply;
  endfunction

  task automatic add_word(input command_t cmd, input word_data_t value,
                          input word_data_t prio);
    queue_word_t w;
    w.cmd   = cmd;
    w.value = value;
    w.prio  = prio;
    pending_words.push_back(w);
    words_total++;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR: reply %0d: %s", replies_checked, msg);
    mismatch_count++;
  endtask

  // Priorities come in classes: fully random, a tight cluster around zero
  // so that equal priorities are common, the signed minimum and maximum with
  // zero and minus one, and values at or just inside the signed limits.
  function automatic word_data_t pick_prio();
    word_data_t p;
    case ($urandom_range(3))
      0: p = $urandom;
      1: p = $urandom_range(4) - 2;
      2: begin
        case ($urandom_range(3))
          0: p = 32'h8000_0000;
          1: p = 32'h7FFF_FFFF;
          2: p = '0;
          default: p = '1;
        endcase
      end
      default: p = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                     : 32'h7FFF_FFFF - $urandom_range(3);
    endcase
    return p;
  endfunction

  // The idle rates change with progress: first the sender idles lightly
  // and the receiver heavily, then the other way round, then neither idles.
  function automatic int phase_of_run();
    if (words_accepted < words_total / 3) return 0;
    if (words_accepted < (2 * words_total) / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (phase_of_run())
      0: return 34;
      1: return 60;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (phase_of_run())
      0: return 60;
      1: return 34;
      default: return 0;
    endcase
  endfunction

  // Driver. A word counts as accepted at an edge where valid is high and
  // stall is low; only then, or when nothing is offered, may the next word
  // be put on the bus. A stalled word is held unchanged.
  always @(posedge clk) begin : driver
    queue_word_t  w;
    queue_reply_t reply;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        w.cmd   = command_t'(in_command);
        w.value = in_item_value;
        w.prio  = in_item_priority;
        reply = serve_word(w);
        owed_replies.push_back(reply);
        words_accepted <= words_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          w = pending_words.pop_front();
          in_valid         <= 1'b1;
          in_command       <= w.cmd;
          in_item_value    <= w.value;
          in_item_priority <= w.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the receiver. It fires once early in the run and once
  // in the phase where the sender never idles, so the output register stays
  // occupied and the input is forced to stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && words_accepted >= 300) ||
                 (holds_done == 1 && words_accepted >= 1150)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor. Every reply taken is matched against the oldest one owed.
  always @(posedge clk) begin : monitor
    queue_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch($sformatf("reply with none owed, status %0d", out_status));
        end else begin
          want = owed_replies.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status expected %0d, got %0d",
                                    want.status, out_status));
          if (out_removed_value !== want.value)
            flag_mismatch($sformatf("removed value expected %h, got %h",
                                    want.value, out_removed_value));
          if (out_removed_priority !== want.prio)
            flag_mismatch($sformatf("removed priority expected %h, got %h",
                                    want.prio, out_removed_priority));
        end
        replies_checked++;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d replies still owed",
               cycle_count, owed_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int   random_words;
    int   burst_len;
    int   insert_pct;
    int   mode;
    // Directed opening: a delete on the empty queue, then sixteen inserts
    // that fill it (data and priority extremes plus three interleaved runs
    // of equal priority), an insert refused as full even though its
    // priority equals the head's, and a few deletes from the head.
    add_word(CMD_DELETE, 32'h1234_5678, 32'h8765_4321);
    add_word(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    add_word(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_word(CMD_INSERT, 32'h0000_0000, 32'h8000_0000);
    add_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < SPQ_CAPACITY - 4; i++)
      add_word(CMD_INSERT, 100 + i, (i % 3) - 1);
    add_word(CMD_INSERT, 32'hDEAD_BEEF, 32'h8000_0000);
    for (int i = 0; i < 6; i++)
      add_word(CMD_DELETE, $urandom, $urandom);

    // Random bursts, each leaning toward filling, draining or a mix, so the
    // queue keeps reaching both its full and its empty boundary.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      burst_len = $urandom_range(40, 4);
      mode = $urandom_range(2);
      insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(99) < insert_pct)
          add_word(CMD_INSERT, $urandom, pick_prio());
        else
          add_word(CMD_DELETE, $urandom, $urandom);
        random_words++;
      end
    end

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Poll away from the active edge so the counters read here are settled.
    while (words_accepted != words_total) @(negedge clk);
    while (owed_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d inserts (%0d refused as full) and %0d deletes (%0d on empty).",
             insert_count, full_hits, delete_count, empty_hits);
    $display("Checked %0d replies; deepest fill %0d of %0d; %0d long receiver holds.",
             replies_checked, deepest_fill, SPQ_CAPACITY, holds_done);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
dv/sorted_priority_queue_test.sv
